// File: sv/sv39ptw_pkg.sv
// Shared constants, codes and controller/datapath interface types of the Sv39 walker.
package sv39ptw_pkg;

	// Store geometry
	localparam int STORE_WORDS   = 4096;
	localparam int TABLE_ENTRIES = 512;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int ADDR_W        = $clog2(STORE_WORDS);
	localparam int TABLE_PAGES   = STORE_WORDS / TABLE_ENTRIES;

	// Field widths
	localparam int WIDX_W = 12;
	localparam int PTE_W  = 64;
	localparam int VA_W   = 64;
	localparam int ROOT_W = 3;
	localparam int CFG_W  = 3;
	localparam int IN_W   = 144;
	localparam int OUT_W  = 136;

	// Entry bit positions
	localparam int BIT_VALID = 0;
	localparam int BIT_USER  = 4;
	localparam int VA_TOP    = 38;

	// Configuration register indexes
	localparam logic CFG_ROOT = 1'b0;
	localparam logic CFG_USER = 1'b1;

	// Request kinds
	localparam logic REQ_WRITE = 1'b0;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_RANGE    = 3'd1,
		STAT_INVALID  = 3'd2,
		STAT_NOT_USER = 3'd3,
		STAT_OUTSIDE  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_L2,
		S_L1,
		S_L0
	} state_t;

	typedef enum logic [1:0] {
		RD_ROOT,
		RD_MID,
		RD_LEAF
	} rd_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic    clr_we;
		logic    take;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    st_we;
		logic    res_load;
		status_t res_status;
		logic    res_ok;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic clr_last;
		logic is_write;
		logic wr_bad;
		logic va_bad;
		logic root_bad;
		logic pte_valid;
		logic ptr_bad;
		logic user_miss;
	} sts_t;

endpackage

// File: sv/sv39_page_table_walk_unit.sv
// Top level of the Sv39 page-table walker.
//
//   channel   signals                          transaction
//   s_*       tvalid tready tdata[143:0] tuser  write one entry or translate one address
//   m_*       tvalid tready tdata[135:0]        status and addresses, one per input
//   cfg_*     we addr wdata[2:0]                 write root_table_page or require_user
//
// A full translate is accepted, then reads one entry-store word per level through the
// single registered read port; one that fails at the top level, and a write, end after
// the first read, and one that fails at the middle level ends after the second.
// After reset the store is swept to zero, all 4096 words, one word per cycle,
// and s_tready stays low; configuration writes are taken meanwhile.
// A finished result waits in the output register while the next item is taken;
// an item stalls in the state that forms its result until that register is free.
module sv39_page_table_walk_unit import sv39ptw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // word_index[11:0], entry_value[75:12], virt_addr[139:76]
	input  logic             s_tuser,   // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // status[2:0], page_addr[66:3], phys_addr[130:67]
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	sv39ptw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sv39ptw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

endmodule

// File: sv/sv39ptw_dp.sv
// Datapath of the Sv39 walker: entry store, item registers, config registers, result register.
module sv39ptw_dp import sv39ptw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [IN_W-1:0]     s_tdata,
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,
	input  logic                cfg_we,
	input  logic                cfg_addr,
	input  logic [CFG_W-1:0]    cfg_wdata
);

	logic [PTE_W-1:0]  store_mem [STORE_WORDS];
	logic [PTE_W-1:0]  rdata_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ROOT_W-1:0] root_q;
	logic              req_user_q;
	logic              req_q;
	logic [WIDX_W-1:0] widx_q;
	logic [PTE_W-1:0]  value_q;
	logic [VA_W-1:0]   va_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [63:0]       page_q;
	logic [63:0]       phys_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [53:0]       ptr;
	logic [VA_W-1:0]   in_va;

	// Form a store address from a table page and an index
	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [53:0] page,
			input logic [IDX_W-1:0] idx);
		logic [63:0] full;
		full = (64'(page) << IDX_W) | 64'(idx);
		return full[ADDR_W-1:0];
	endfunction

	assign in_va = s_tdata[139:76];
	assign ptr   = rdata_q[63:10];

	// Select the read address for the level being fetched
	always_comb begin
		case (cmd.rd_sel)
			RD_ROOT: rd_addr = tbl_addr(54'(root_q), in_va[38:30]);
			RD_MID:  rd_addr = tbl_addr(ptr, va_q[29:21]);
			RD_LEAF: rd_addr = tbl_addr(ptr, va_q[20:12]);
			default: rd_addr = tbl_addr(ptr, va_q[20:12]);
		endcase
	end

	// Entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			store_mem[clr_q] <= '0;
		end else if (cmd.st_we) begin
			store_mem[ADDR_W'(widx_q)] <= value_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= store_mem[rd_addr];
		end
	end

	// Step the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q     <= '0;
			req_user_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ROOT: root_q     <= cfg_wdata[ROOT_W-1:0];
				CFG_USER: req_user_q <= cfg_wdata[0];
				default:  root_q     <= root_q;
			endcase
		end
	end

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q   <= s_tuser;
			widx_q  <= s_tdata[11:0];
			value_q <= s_tdata[75:12];
			va_q    <= in_va;
		end
	end

	// Status toward the controller
	always_comb begin
		sts.out_free  = !out_valid_q || m_tready;
		sts.clr_last  = &clr_q;
		sts.is_write  = (req_q == REQ_WRITE);
		sts.wr_bad    = 17'(widx_q) >= 17'(STORE_WORDS);
		sts.va_bad    = |va_q[VA_W-1:VA_TOP];
		sts.root_bad  = 17'(root_q) >= 17'(TABLE_PAGES);
		sts.pte_valid = rdata_q[BIT_VALID];
		sts.ptr_bad   = ptr >= 54'(TABLE_PAGES);
		sts.user_miss = req_user_q && !rdata_q[BIT_USER];
	end

	// Result register and its valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			if (cmd.res_ok) begin
				page_q <= {rdata_q[61:10], 12'b0};
				phys_q <= {rdata_q[61:10], va_q[11:0]};
			end else begin
				page_q <= '0;
				phys_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, phys_q, page_q, status_q};

endmodule

// File: sv/sv39ptw_ctrl.sv
// Controller of the Sv39 walker: clearing pass, level sequencing and status selection.
module sv39ptw_ctrl import sv39ptw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) state_d = S_L2;
			end
			S_L2: begin
				if (!sts.is_write && !sts.va_bad && !sts.root_bad && sts.pte_valid
						&& !sts.ptr_bad) begin
					state_d = S_L1;
				end else if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_L1: begin
				if (sts.pte_valid && !sts.ptr_bad) begin
					state_d = S_L0;
				end else if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_L0: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Commands
	always_comb begin
		s_tready       = 1'b0;
		cmd.clr_we     = 1'b0;
		cmd.take       = 1'b0;
		cmd.rd_en      = 1'b0;
		cmd.rd_sel     = RD_ROOT;
		cmd.st_we      = 1'b0;
		cmd.res_load   = 1'b0;
		cmd.res_status = STAT_OK;
		cmd.res_ok     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
			end
			S_IDLE: begin
				// Fetch the top-level entry as the transaction is taken
				s_tready   = 1'b1;
				cmd.take   = s_tvalid;
				cmd.rd_en  = s_tvalid;
				cmd.rd_sel = RD_ROOT;
			end
			S_L2: begin
				if (sts.is_write) begin
					cmd.res_load   = sts.out_free;
					cmd.st_we      = sts.out_free && !sts.wr_bad;
					cmd.res_status = sts.wr_bad ? STAT_OUTSIDE : STAT_OK;
				end else if (sts.va_bad) begin
					cmd.res_load   = sts.out_free;
					cmd.res_status = STAT_RANGE;
				end else if (sts.root_bad) begin
					cmd.res_load   = sts.out_free;
					cmd.res_status = STAT_OUTSIDE;
				end else if (!sts.pte_valid) begin
					cmd.res_load   = sts.out_free;
					cmd.res_status = STAT_INVALID;
				end else if (sts.ptr_bad) begin
					cmd.res_load   = sts.out_free;
					cmd.res_status = STAT_OUTSIDE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_MID;
				end
			end
			S_L1: begin
				if (!sts.pte_valid) begin
					cmd.res_load   = sts.out_free;
					cmd.res_status = STAT_INVALID;
				end else if (sts.ptr_bad) begin
					cmd.res_load   = sts.out_free;
					cmd.res_status = STAT_OUTSIDE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEAF;
				end
			end
			S_L0: begin
				cmd.res_load = sts.out_free;
				if (!sts.pte_valid) begin
					cmd.res_status = STAT_INVALID;
				end else if (sts.user_miss) begin
					cmd.res_status = STAT_NOT_USER;
				end else begin
					cmd.res_status = STAT_OK;
					cmd.res_ok     = 1'b1;
				end
			end
			default: begin
				cmd.clr_we = 1'b0;
			end
		endcase
	end

endmodule

// File: tb/sv39_walk_checker.sv
// Scoreboard for the Sv39 walker: mirrors the entry store, predicts and checks each result.
`timescale 1ns / 100ps

module sv39_walk_checker import sv39ptw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // word_index[11:0], entry_value[75:12], virt_addr[139:76]
	input  logic             s_tuser,   // req_type
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // status[2:0], page_addr[66:3], phys_addr[130:67]
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               mismatch_count,
	output int               results_due
);

	localparam int PAGE_SHIFT = 12;
	localparam int PPN_SHIFT  = 10;
	localparam int TOP_LEVEL  = 2;
	localparam int PRINT_CAP  = 40;
	localparam logic [VA_W-1:0] VA_LIMIT = 64'd1 << VA_TOP;

	typedef struct packed {
		status_t         status;
		logic [PTE_W-1:0] page;
		logic [PTE_W-1:0] phys;
	} walk_res_t;

	logic [PTE_W-1:0]  pte_mirror [STORE_WORDS];
	logic [ROOT_W-1:0] root_mir;
	logic              user_mir;
	walk_res_t         walk_due_q [$];
	int                err_n = 0;

	assign mismatch_count = err_n;

	// Print one line per mismatch (up to a cap) and count every one
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (err_n < PRINT_CAP)
			$display("%0t: walk mismatch on %s: got %h, expected %h", $time, what, got, want);
		err_n++;
	endtask

	// Apply one transaction to the mirror and work out its result
	function automatic walk_res_t predict_walk(input logic kind, input logic [WIDX_W-1:0] widx,
			input logic [PTE_W-1:0] val, input logic [VA_W-1:0] va);
		walk_res_t        res;
		logic [63:0]      tbl;
		logic [PTE_W-1:0] pte;
		logic [63:0]      base;
		logic [IDX_W-1:0] idx;
		int               lvl;
		res.status = STAT_OK;
		res.page = '0;
		res.phys = '0;
		if (kind == REQ_WRITE) begin
			if (int'(widx) >= STORE_WORDS)
				res.status = STAT_OUTSIDE;
			else
				pte_mirror[widx] = val;
			return res;
		end
		if (va >= VA_LIMIT) begin
			res.status = STAT_RANGE;
			return res;
		end
		tbl = 64'(root_mir);
		for (lvl = TOP_LEVEL; lvl >= 0; lvl--) begin
			if (tbl >= 64'(TABLE_PAGES)) begin
				res.status = STAT_OUTSIDE;
				return res;
			end
			idx = IDX_W'(va >> (PAGE_SHIFT + IDX_W * lvl));
			pte = pte_mirror[int'(tbl) * TABLE_ENTRIES + int'(idx)];
			if (!pte[BIT_VALID]) begin
				res.status = STAT_INVALID;
				return res;
			end
			// any valid upper entry is a pointer; large pages do not exist here
			if (lvl > 0) begin
				tbl = pte >> PPN_SHIFT;
			end else if (user_mir && !pte[BIT_USER]) begin
				res.status = STAT_NOT_USER;
				return res;
			end else begin
				base = (pte >> PPN_SHIFT) << PAGE_SHIFT;
				res.page = base;
				res.phys = base + {52'd0, va[PAGE_SHIFT-1:0]};
				return res;
			end
		end
		res.status = STAT_INVALID;
		return res;
	endfunction

	// Track config writes, predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		walk_res_t got;
		walk_res_t want;
		if (!arst_n) begin
			root_mir = '0;
			user_mir = 1'b1;
			for (int i = 0; i < STORE_WORDS; i++)
				pte_mirror[i] = '0;
			walk_due_q.delete();
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_ROOT)
					root_mir = cfg_wdata[ROOT_W-1:0];
				else if (cfg_addr == CFG_USER)
					user_mir = cfg_wdata[0];
			end
			if (s_tvalid && s_tready)
				walk_due_q.push_back(predict_walk(s_tuser, s_tdata[11:0], s_tdata[75:12],
					s_tdata[139:76]));
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tdata[2:0]);
				got.page = m_tdata[66:3];
				got.phys = m_tdata[130:67];
				if (walk_due_q.size() == 0) begin
					report_mismatch("result with nothing due", 64'(got.status), 64'(0));
				end else begin
					want = walk_due_q.pop_front();
					if (got.status != want.status)
						report_mismatch("status", 64'(got.status), 64'(want.status));
					if (got.page != want.page)
						report_mismatch("page_addr", got.page, want.page);
					if (got.phys != want.phys)
						report_mismatch("phys_addr", got.phys, want.phys);
				end
			end
			results_due <= walk_due_q.size();
		end
	end

endmodule

// File: tb/sv39_page_table_walk_unit_test.sv
// Stimulus and verdict for the Sv39 page-table walker, with the scoreboard beside the block.
`timescale 1ns / 100ps

module sv39_page_table_walk_unit_test import sv39ptw_pkg::*; ();

	localparam logic REQ_XLATE   = 1'b1;
	localparam int   CYCLE_LIMIT = 200000;
	localparam int   PHASE_ITEMS = 80;
	localparam int   PHASES      = 5;
	localparam int   PPN_SHIFT   = 10;
	localparam int   TAIL_CYCLES = 8;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;   // word_index[11:0], entry_value[75:12], virt_addr[139:76]
	logic             s_tuser   = 1'b0; // req_type
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;          // status[2:0], page_addr[66:3], phys_addr[130:67]
	logic             cfg_we    = 1'b0;
	logic             cfg_addr  = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	int                fail_cnt;
	int                pend_cnt;
	int                cycle_cnt   = 0;
	int                items_sent  = 0;
	int                burst_left  = 1;
	logic [ROOT_W-1:0] root_now    = '0;
	rx_mode_t          rx_mode     = RX_OPEN;
	int                rx_left     = 0;
	logic [3:0]        rx_tick     = '0;

	sv39_page_table_walk_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	sv39_walk_checker walk_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (fail_cnt),
		.results_due    (pend_cnt)
	);

	always #4 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stall the result side on a random pattern that is picked anew whenever its countdown runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_left <= 0;
			rx_tick <= '0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(32, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:     m_tready <= 1'b1;
				RX_COIN:     m_tready <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: m_tready <= (rx_tick >= 4'd5);
				default:     m_tready <= ($urandom_range(0, 3) == 0);
			endcase
			rx_tick <= rx_tick + 4'd1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Table pointer to page pg with random flag bits
	function automatic logic [63:0] table_ptr(input logic [63:0] pg);
		return (pg << PPN_SHIFT) | (rand64() & 64'h3FE) | 64'h1;
	endfunction

	// Page number beyond the store, near the edge or anywhere
	function automatic logic [63:0] outside_page();
		if ($urandom_range(0, 1) == 0)
			return 64'($urandom_range(TABLE_PAGES, 2 * TABLE_PAGES - 1));
		return (rand64() >> PPN_SHIFT) | 64'(TABLE_PAGES);
	endfunction

	// Hold one transaction until taken; close the burst with a gap when it runs out
	task automatic push_req(input logic kind, input logic [WIDX_W-1:0] widx,
			input logic [PTE_W-1:0] val, input logic [VA_W-1:0] va);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'd0, va, val, widx};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
		end
	endtask

	task automatic wr(input logic [WIDX_W-1:0] widx, input logic [PTE_W-1:0] val);
		push_req(REQ_WRITE, widx, val, rand64());
	endtask

	task automatic xlate(input logic [VA_W-1:0] va);
		push_req(REQ_XLATE, WIDX_W'($urandom), rand64(), va);
	endtask

	// Drop valid and wait until every result has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pend_cnt != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Build a three-level chain, sometimes broken, then translate through it
	task automatic map_and_probe();
		logic [IDX_W-1:0] v2;
		logic [IDX_W-1:0] v1;
		logic [IDX_W-1:0] v0;
		logic [IDX_W-1:0] v0_probe;
		logic [63:0]      t1;
		logic [63:0]      t0;
		logic [63:0]      leaf;
		int               drop;
		v2 = IDX_W'($urandom);
		v2[IDX_W-1] = 1'b0;   // address bit 38 must stay clear to pass the range check
		v1 = IDX_W'($urandom);
		v0 = IDX_W'($urandom);
		t1 = 64'($urandom_range(0, TABLE_PAGES - 1));
		t0 = 64'($urandom_range(0, TABLE_PAGES - 1));
		if ($urandom_range(0, 11) == 0)
			t1 = outside_page();
		if ($urandom_range(0, 11) == 0)
			t0 = outside_page();
		leaf = rand64();
		leaf[BIT_VALID] = ($urandom_range(0, 9) != 0);
		leaf[BIT_USER] = ($urandom_range(0, 3) != 0);
		drop = $urandom_range(0, 11);
		if (drop != 1)
			wr({root_now, v2}, table_ptr(t1));
		if (drop != 2)
			wr({t1[ROOT_W-1:0], v1}, table_ptr(t0));
		if (drop != 3)
			wr({t0[ROOT_W-1:0], v0}, leaf);
		repeat ($urandom_range(1, 3)) begin
			v0_probe = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : v0;
			xlate({25'd0, v2, v1, v0_probe, 12'($urandom)});
		end
	endtask

	initial begin
		logic [63:0]       va_tmp;
		logic              user_now;
		int                pick;
		int                goal;
		burst_left = $urandom_range(1, 12);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Program registers while the store is being cleared
		root_now = 3'd0;
		write_reg(CFG_ROOT, 3'd0);
		write_reg(CFG_USER, {2'($urandom), 1'b1});

		// Cleared store, range edges
		xlate(64'h0);
		xlate(64'h40_0000_0000);
		xlate({64{1'b1}});
		xlate(64'h3F_FFFF_FFFF);
		// Full chain to an all-ones leaf
		wr(12'd0, table_ptr(64'd1));
		wr(12'd512, table_ptr(64'd2));
		wr(12'd1024, {64{1'b1}});
		xlate(64'hFFF);
		// Leaf without the user bit, invalid leaf
		wr(12'd1025, 64'hFFFF_FFFF_FFFF_FFEF);
		xlate(64'h1123);
		xlate(64'h2000);
		// Pointers outside the store at both upper levels
		wr(12'd513, table_ptr(64'd9));
		xlate(64'h20_0000);
		wr(12'd1, {64{1'b1}});
		xlate(64'h4000_0000);
		// Chain through the top table page to a leaf at page zero
		wr(12'd2, table_ptr(64'd7));
		wr(12'd3584, (64'd3 << PPN_SHIFT) | 64'h3FF);
		wr(12'd1541, 64'h1);
		xlate(64'h8000_5ABC);
		// Last store word, reached at level one
		wr(12'd4095, {64{1'b1}});
		xlate(64'hBFE0_0000);

		// Without the user check both user-less leaves translate
		wait_idle();
		write_reg(CFG_USER, {2'($urandom), 1'b0});
		xlate(64'h8000_5ABC);
		xlate(64'h1123);

		// Top root page
		wait_idle();
		root_now = 3'd7;
		write_reg(CFG_ROOT, 3'd7);
		xlate(64'h0);
		xlate(64'h3F_FFFF_FFFF);

		// Random phases, each under its own settings
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					root_now = 3'd7;
					user_now = 1'b0;
				end
				1: begin
					root_now = 3'd0;
					user_now = 1'b1;
				end
				default: begin
					root_now = ROOT_W'($urandom);
					user_now = 1'($urandom_range(0, 1));
				end
			endcase
			write_reg(CFG_ROOT, root_now);
			write_reg(CFG_USER, {2'($urandom), user_now});
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					map_and_probe();
				end else if (pick < 75) begin
					xlate(rand64() & ((64'd1 << VA_TOP) - 64'd1));
				end else if (pick < 85) begin
					va_tmp = rand64();
					va_tmp[$urandom_range(VA_TOP, VA_W - 1)] = 1'b1;
					xlate(va_tmp);
				end else begin
					wr(WIDX_W'($urandom), rand64());
				end
			end
		end

		// Drain and give the verdict
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
